FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/bef_pkg.sv
// ----------------------------------------------------------------------------
// bef_pkg
// Types, codes and constants of the button and encoder event front end.
// ----------------------------------------------------------------------------
package bef_pkg;

  localparam int unsigned BTN_W        = 16;
  localparam int unsigned BIT_W        = 4;
  localparam int unsigned TQ_DEPTH_DEF = 16;

  typedef enum logic {
    OP_POLL = 1'b0,
    OP_EDGE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    EV_HOLD_INDEX  = 3'd0,
    EV_HOLD_NONE   = 3'd1,
    EV_ALARM       = 3'd2,
    EV_ENC_PRESS   = 3'd3,
    EV_TURN_CW     = 3'd4,
    EV_TURN_CCW    = 3'd5
  } event_kind_t;

  typedef enum logic [1:0] {
    CFG_HOLD_MASK = 2'd0,
    CFG_ALARM_BIT = 2'd1,
    CFG_ENC_BIT   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t              operation;
    logic [BTN_W-1:0] button_sample;
    logic             pin_a_level;
    logic             pin_b_level;
  } in_item_t;

  typedef struct packed {
    event_kind_t      event_kind;
    logic [BIT_W-1:0] button_index;
    logic             toggle_level;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic push_cw;
    logic pop;
  } tq_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic more;
    logic head_cw;
  } tq_stat_t;

endpackage

FILE: design/bef_turn_queue.sv
// ----------------------------------------------------------------------------
// bef_turn_queue
// Ring of turn direction bits with write and read positions and a fill count.
// ----------------------------------------------------------------------------
module bef_turn_queue #(
  parameter int unsigned DEPTH = bef_pkg::TQ_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bef_pkg::tq_ctrl_t  ctrl,
  output bef_pkg::tq_stat_t  stat
);
  import bef_pkg::*;

  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  logic [DEPTH-1:0]  ring_r;
  logic [PTR_W-1:0]  wr_r, wr_nxt;
  logic [PTR_W-1:0]  rd_r, rd_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              do_push, do_pop;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] last;
    last = PTR_W'(DEPTH - 1);
    return (p == last) ? '0 : p + 1'b1;
  endfunction

  assign do_push = ctrl.push && !stat.full;
  assign do_pop  = ctrl.pop && !stat.empty;

  always_comb begin
    wr_nxt   = do_push ? advance(wr_r) : wr_r;
    rd_nxt   = do_pop ? advance(rd_r) : rd_r;
    fill_nxt = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ring_r[wr_r] <= ctrl.push_cw;
    end
  end

  assign stat.empty   = (fill_r == '0);
  assign stat.full    = (fill_r == FILL_W'(DEPTH));
  assign stat.more    = (fill_r > FILL_W'(1));
  assign stat.head_cw = ring_r[rd_r];

endmodule

FILE: design/bef_hold_scan.sv
// ----------------------------------------------------------------------------
// bef_hold_scan
// Shift unit that finds the position of the single set bit, one bit a cycle.
// ----------------------------------------------------------------------------
module bef_hold_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bef_pkg::BTN_W-1:0] vec,
  output logic                      done,
  output logic [bef_pkg::BIT_W-1:0] index
);
  import bef_pkg::*;

  logic [BTN_W-1:0] sh_r, sh_nxt;
  logic [BIT_W-1:0] idx_r, idx_nxt;
  logic             run_r, run_nxt;
  logic             hit;

  assign hit  = sh_r[0] || (sh_r == '0);
  assign done = run_r && hit;
  assign index = idx_r;

  always_comb begin
    sh_nxt  = sh_r;
    idx_nxt = idx_r;
    run_nxt = run_r;
    if (start) begin
      sh_nxt  = vec;
      idx_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (hit) begin
        run_nxt = 1'b0;
      end else begin
        sh_nxt  = sh_r >> 1;
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    idx_r <= idx_nxt;
  end

endmodule

FILE: design/button_and_encoder_event_front_end.sv
// ----------------------------------------------------------------------------
// button_and_encoder_event_front_end
// Button change detector with an exclusive hold group, alarm toggle and
// encoder press events, and a queue of encoder turns drained by each poll.
//
//   Channel | Ports                           | Moves
//   input   | in_valid, in_stall, in_item     | button poll or encoder edge
//   output  | out_valid, out_stall, out_item  | one event per transfer
//   config  | cfg_we, cfg_index, cfg_wdata    | register write
//
// An encoder edge is pushed into the turn queue unless it is full, and the
// sequencer stays in idle. A poll is accepted in idle, passes through the
// shift unit when one hold button is held, and issues its results (up to 19
// at the default queue depth) through the single output register before
// returning to idle. Stalls on the output hold the sequencer; no new item is
// taken until a poll's results are all issued. Reset is synchronous.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module button_and_encoder_event_front_end #(
  parameter int unsigned TURN_QUEUE_DEPTH = bef_pkg::TQ_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bef_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bef_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  bef_pkg::cfg_idx_t         cfg_index,
  input  logic [bef_pkg::BTN_W-1:0] cfg_wdata
);
  import bef_pkg::*;

  state_t           state_r, state_nxt;
  logic [BTN_W-1:0] mask_r, prev_r, prev_nxt;
  logic [BIT_W-1:0] alarm_bit_r, enc_bit_r;
  logic             hold_pend_r, hold_pend_nxt;
  logic             hold_one_r, hold_one_nxt;
  logic [BIT_W-1:0] hold_idx_r, hold_idx_nxt;
  logic             alarm_pend_r, alarm_pend_nxt;
  logic             alarm_lvl_r, alarm_lvl_nxt;
  logic             enc_pend_r, enc_pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             in_acc, slot_free, emit;
  logic [BTN_W-1:0] changed, held;
  logic             held_one;
  logic             scan_start, scan_done;
  logic [BIT_W-1:0] scan_idx;
  tq_ctrl_t         q_ctrl;
  tq_stat_t         q_stat;

  bef_turn_queue #(
    .DEPTH (TURN_QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (q_ctrl),
    .stat  (q_stat)
  );

  bef_hold_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .vec   (held),
    .done  (scan_done),
    .index (scan_idx)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign changed  = in_item.button_sample ^ prev_r;
  assign held     = in_item.button_sample & mask_r;
  assign held_one = (held != '0) && ((held & (held - 1'b1)) == '0);

  always_comb begin
    state_nxt      = state_r;
    prev_nxt       = prev_r;
    hold_pend_nxt  = hold_pend_r;
    hold_one_nxt   = hold_one_r;
    hold_idx_nxt   = hold_idx_r;
    alarm_pend_nxt = alarm_pend_r;
    alarm_lvl_nxt  = alarm_lvl_r;
    enc_pend_nxt   = enc_pend_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_item_nxt   = out_item_r;
    scan_start     = 1'b0;
    emit           = 1'b0;
    q_ctrl         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item.operation == OP_EDGE) begin
            q_ctrl.push    = !q_stat.full;
            q_ctrl.push_cw = in_item.pin_a_level ^ in_item.pin_b_level;
          end else begin
            prev_nxt       = in_item.button_sample;
            hold_pend_nxt  = ((changed & mask_r) != '0);
            hold_one_nxt   = held_one;
            hold_idx_nxt   = '0;
            alarm_pend_nxt = changed[alarm_bit_r];
            alarm_lvl_nxt  = in_item.button_sample[alarm_bit_r];
            enc_pend_nxt   = changed[enc_bit_r] && in_item.button_sample[enc_bit_r];
            if (hold_pend_nxt && held_one) begin
              scan_start = 1'b1;
              state_nxt  = ST_SCAN;
            end else begin
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          hold_idx_nxt = scan_idx;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!(hold_pend_r || alarm_pend_r || enc_pend_r || !q_stat.empty)) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          emit          = 1'b1;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{event_kind: EV_HOLD_NONE, button_index: '0,
                            toggle_level: 1'b0, last_of_run: 1'b0};
          if (hold_pend_r) begin
            hold_pend_nxt = 1'b0;
            if (hold_one_r) begin
              out_item_nxt.event_kind   = EV_HOLD_INDEX;
              out_item_nxt.button_index = hold_idx_r;
            end
            out_item_nxt.last_of_run = !(alarm_pend_r || enc_pend_r || !q_stat.empty);
          end else if (alarm_pend_r) begin
            alarm_pend_nxt            = 1'b0;
            out_item_nxt.event_kind   = EV_ALARM;
            out_item_nxt.toggle_level = alarm_lvl_r;
            out_item_nxt.last_of_run  = !(enc_pend_r || !q_stat.empty);
          end else if (enc_pend_r) begin
            enc_pend_nxt             = 1'b0;
            out_item_nxt.event_kind  = EV_ENC_PRESS;
            out_item_nxt.last_of_run = q_stat.empty;
          end else begin
            q_ctrl.pop               = 1'b1;
            out_item_nxt.event_kind  = q_stat.head_cw ? EV_TURN_CW : EV_TURN_CCW;
            out_item_nxt.last_of_run = !q_stat.more;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mask_r       <= '0;
      alarm_bit_r  <= '0;
      enc_bit_r    <= '0;
      prev_r       <= '0;
      hold_pend_r  <= 1'b0;
      alarm_pend_r <= 1'b0;
      enc_pend_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      prev_r       <= prev_nxt;
      hold_pend_r  <= hold_pend_nxt;
      alarm_pend_r <= alarm_pend_nxt;
      enc_pend_r   <= enc_pend_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HOLD_MASK: mask_r      <= cfg_wdata;
          CFG_ALARM_BIT: alarm_bit_r <= cfg_wdata[BIT_W-1:0];
          CFG_ENC_BIT:   enc_bit_r   <= cfg_wdata[BIT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_one_r  <= hold_one_nxt;
    hold_idx_r  <= hold_idx_nxt;
    alarm_lvl_r <= alarm_lvl_nxt;
    out_item_r  <= out_item_nxt;
  end

  `ASSERT_IMP(a_idle_last, clk, rst_n, state_r == ST_IDLE && out_valid_r, out_item_r.last_of_run)
  `ASSERT_IMP(a_scan_only_in_scan, clk, rst_n, scan_done, state_r == ST_SCAN)
  `ASSERT_NEXT(a_run_drains, clk, rst_n, state_r == ST_EMIT && state_nxt == ST_IDLE, q_stat.empty)
  `ASSERT_IMP(a_emit_has_slot, clk, rst_n, emit, slot_free && (state_r == ST_EMIT))

endmodule

FILE: tb/tb_button_and_encoder_event_front_end.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_and_encoder_event_front_end
// Self-checking testbench for the button and encoder event front end. Polls
// and encoder edges are sent with random gaps while the event output is
// stalled at random, apart from one quiet phase. A behavioral model of the
// change detector and turn queue predicts every event, and each event taken
// from the output is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_button_and_encoder_event_front_end;
  import bef_pkg::*;

  localparam int unsigned TURN_DEPTH   = TQ_DEPTH_DEF;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 40;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;
  logic              cfg_we    = 1'b0;
  cfg_idx_t          cfg_index = CFG_HOLD_MASK;
  logic [BTN_W-1:0]  cfg_wdata = '0;

  // Model registers and state.
  logic [15:0]       hold_mask;
  logic [3:0]        alarm_pos;
  logic [3:0]        press_pos;
  logic [15:0]       last_buttons;
  logic              turn_ring [TURN_DEPTH];
  logic [3:0]        turn_wr;
  logic [3:0]        turn_rd;
  int unsigned       turn_count;

  out_item_t         pending_events [$];
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;
  bit                quiet = 1'b0;

  button_and_encoder_event_front_end #(
    .TURN_QUEUE_DEPTH(TURN_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 13);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected event, expected none, actual %p", $time, out_item);
      end else begin
        want = pending_events.pop_front();
        if (out_item.event_kind !== want.event_kind) begin
          mismatch_count++;
          $display("%0t: event_kind expected %0d actual %0d", $time,
                   want.event_kind, out_item.event_kind);
        end
        if (out_item.button_index !== want.button_index) begin
          mismatch_count++;
          $display("%0t: button_index expected %0d actual %0d", $time,
                   want.button_index, out_item.button_index);
        end
        if (out_item.toggle_level !== want.toggle_level) begin
          mismatch_count++;
          $display("%0t: toggle_level expected %0d actual %0d", $time,
                   want.toggle_level, out_item.toggle_level);
        end
        if (out_item.last_of_run !== want.last_of_run) begin
          mismatch_count++;
          $display("%0t: last_of_run expected %0d actual %0d", $time,
                   want.last_of_run, out_item.last_of_run);
        end
      end
    end
  end

  function automatic out_item_t make_event(input event_kind_t kind, input logic [3:0] idx,
                                           input logic lvl);
    out_item_t ev;
    ev.event_kind   = kind;
    ev.button_index = idx;
    ev.toggle_level = lvl;
    ev.last_of_run  = 1'b0;
    return ev;
  endfunction

  function automatic void predict_events(input in_item_t it);
    logic [15:0] changed;
    logic [15:0] held;
    logic [15:0] alarm_bit;
    logic [15:0] press_bit;
    logic [3:0]  idx;
    out_item_t   run [$];
    if (it.operation == OP_EDGE) begin
      if (turn_count < TURN_DEPTH) begin
        turn_ring[turn_wr] = it.pin_a_level ^ it.pin_b_level;
        turn_wr = turn_wr + 4'd1;
        turn_count++;
      end
      return;
    end
    changed      = it.button_sample ^ last_buttons;
    alarm_bit    = 16'h0001 << alarm_pos;
    press_bit    = 16'h0001 << press_pos;
    last_buttons = it.button_sample;
    if ((changed & hold_mask) != 16'h0000) begin
      held = it.button_sample & hold_mask;
      if (held != 16'h0000 && (held & (held - 16'h0001)) == 16'h0000) begin
        idx = 4'd0;
        for (int i = 0; i < 16; i++) begin
          if (held[i]) idx = i[3:0];
        end
        run.push_back(make_event(EV_HOLD_INDEX, idx, 1'b0));
      end else begin
        run.push_back(make_event(EV_HOLD_NONE, 4'd0, 1'b0));
      end
    end
    if ((changed & alarm_bit) != 16'h0000) begin
      run.push_back(make_event(EV_ALARM, 4'd0, (it.button_sample & alarm_bit) != 16'h0000));
    end
    if ((changed & press_bit & it.button_sample) != 16'h0000) begin
      run.push_back(make_event(EV_ENC_PRESS, 4'd0, 1'b0));
    end
    while (turn_count > 0) begin
      run.push_back(make_event(turn_ring[turn_rd] ? EV_TURN_CW : EV_TURN_CCW, 4'd0, 1'b0));
      turn_rd = turn_rd + 4'd1;
      turn_count--;
    end
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) pending_events.push_back(run[i]);
  endfunction

  task automatic send_item(input in_item_t it);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_events(it);
  endtask

  task automatic send_poll(input logic [15:0] sample);
    in_item_t it;
    it.operation     = OP_POLL;
    it.button_sample = sample;
    it.pin_a_level   = 1'($urandom_range(1));
    it.pin_b_level   = 1'($urandom_range(1));
    send_item(it);
  endtask

  task automatic send_edge(input logic a, input logic b);
    in_item_t it;
    it.operation     = OP_EDGE;
    it.button_sample = 16'($urandom);
    it.pin_a_level   = a;
    it.pin_b_level   = b;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] mask, input logic [3:0] alarm,
                              input logic [3:0] press);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HOLD_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_index <= CFG_ALARM_BIT;
    cfg_wdata <= {12'h000, alarm};
    @(posedge clk);
    cfg_index <= CFG_ENC_BIT;
    cfg_wdata <= {12'h000, press};
    @(posedge clk);
    cfg_we    <= 1'b0;
    hold_mask = mask;
    alarm_pos = alarm;
    press_pos = press;
  endtask

  // With the reset settings the alarm and the encoder button share bit zero
  // and the hold group is empty.
  task automatic test_reset_config();
    send_poll(16'h0001);
    send_poll(16'h0000);
  endtask

  // Overfills the turn queue with every pin combination, then a poll that
  // reports all three button events drains the full queue.
  task automatic test_turn_queue_full();
    program_regs(16'h000F, 4'd4, 4'd5);
    for (int i = 0; i < 18; i++) begin
      send_edge(i[0], i[1]);
    end
    send_poll(16'h0031);
  endtask

  task automatic test_hold_group();
    program_regs(16'hFFFF, 4'd15, 4'd15);
    send_poll(16'h8000);
    send_poll(16'hFFFF);
    send_poll(16'hFFFF);
    send_poll(16'h0000);
  endtask

  function automatic logic [15:0] next_sample();
    logic [15:0] pick;
    pick = 16'h0001 << $urandom_range(15);
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return last_buttons ^ pick;
      2:       return (last_buttons & ~hold_mask) | (pick & hold_mask);
      default: return last_buttons;
    endcase
  endfunction

  task automatic test_random_phases();
    int unsigned sent;
    int unsigned burst;
    int unsigned roll;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       program_regs(16'h0000, 4'd0, 4'd15);
        1:       program_regs(16'h0001, 4'd0, 4'd0);
        2:       program_regs(16'hFFFF, 4'd15, 4'd0);
        default: program_regs(16'($urandom), 4'($urandom_range(15)),
                              4'($urandom_range(15)));
      endcase
      quiet = (p == 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          burst = $urandom_range(20, 10);
          repeat (burst) send_edge(1'($urandom_range(1)), 1'($urandom_range(1)));
          sent += burst;
        end else if (roll < 55) begin
          send_edge(1'($urandom_range(1)), 1'($urandom_range(1)));
          sent++;
        end else begin
          send_poll(next_sample());
          sent++;
        end
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    hold_mask    = '0;
    alarm_pos    = '0;
    press_pos    = '0;
    last_buttons = '0;
    turn_wr      = '0;
    turn_rd      = '0;
    turn_count   = 0;
    foreach (turn_ring[i]) turn_ring[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_turn_queue_full();
    test_hold_group();
    test_random_phases();
    wait_drained();
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
